### rtl/core/efp_pkg.sv
package efp_pkg;

	// fixed point format and image geometry
	localparam int FRACTION_BITS    = 28;
	localparam int IMAGE_WIDTH_LOG2  = 10;
	localparam int IMAGE_HEIGHT_LOG2 = 10;
	localparam int IMAGE_WIDTH       = 1 << IMAGE_WIDTH_LOG2;
	localparam int IMAGE_HEIGHT      = 1 << IMAGE_HEIGHT_LOG2;
	localparam int ROW_PITCH         = 1024;

	// field widths
	localparam int WORD_W    = 32;
	localparam int PIX_W     = 10;
	localparam int SHADE_W   = 8;
	localparam int LIMIT_W   = 10;
	localparam int STEP_W    = 8;
	localparam int INDEX_W   = 20;
	localparam int BYTE_W    = 8;
	localparam int CFG_IDX_W = 3;

	// datapath widths
	localparam int DIFF_W = WORD_W + 1;
	localparam int MAP_W  = PIX_W + 1 + DIFF_W;
	localparam int PROD_W = 2 * WORD_W;
	localparam int SQ_W   = PROD_W - FRACTION_BITS;
	localparam int XY_W   = SQ_W + 1;
	localparam int SAT_W  = PROD_W + 4;

	localparam logic [PROD_W:0] ESC_BOUND = (PROD_W + 1)'(4) << FRACTION_BITS;

	localparam int RED_OFFSET   = 680 + 179;
	localparam int GREEN_OFFSET = 42 + 84;
	localparam int BLUE_OFFSET  = 936 + 45;

	localparam logic signed [WORD_W-1:0] RST_LEFT   = -32'sd536870912;
	localparam logic signed [WORD_W-1:0] RST_RIGHT  = 32'sd536870912;
	localparam logic signed [WORD_W-1:0] RST_TOP    = -32'sd536870912;
	localparam logic signed [WORD_W-1:0] RST_BOTTOM = 32'sd536870912;
	localparam logic [LIMIT_W-1:0]       RST_LIMIT  = 10'd100;
	localparam logic [STEP_W-1:0]        RST_STEP   = 8'd1;

	typedef enum logic {
		MODE_MANDEL,
		MODE_SHIP
	} fractal_mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE,
		REG_LEFT,
		REG_RIGHT,
		REG_TOP,
		REG_BOTTOM,
		REG_LIMIT,
		REG_STEP
	} cfg_reg_t;

	typedef struct packed {
		fractal_mode_t               mode;
		logic signed [WORD_W-1:0]    left;
		logic signed [WORD_W-1:0]    right;
		logic signed [WORD_W-1:0]    top;
		logic signed [WORD_W-1:0]    bottom;
		logic [LIMIT_W-1:0]          limit;
		logic [STEP_W-1:0]           step;
	} cfg_t;

	typedef struct packed {
		logic [PIX_W-1:0]   pixel_col;
		logic [PIX_W-1:0]   pixel_row;
		logic [SHADE_W-1:0] shade;
	} in_beat_t;

	typedef struct packed {
		logic [INDEX_W-1:0] pixel_word_index;
		logic [LIMIT_W-1:0] escape_count;
		logic [BYTE_W-1:0]  red_byte;
		logic [BYTE_W-1:0]  green_byte;
		logic [BYTE_W-1:0]  blue_byte;
	} out_beat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAP,
		ST_LOAD,
		ST_MUL,
		ST_STEP,
		ST_PAINT,
		ST_EMIT
	} fsm_state_t;

	typedef struct packed {
		logic take;
		logic map;
		logic load;
		logic mul;
		logic step;
		logic paint;
		logic emit;
		logic busy;
	} seq_ctl_t;

	typedef struct packed {
		logic escaped;
		logic at_limit;
		logic out_hold;
	} seq_stat_t;

	function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [SAT_W-1:0] v);
		logic signed [SAT_W-1:0] hi;
		logic signed [SAT_W-1:0] lo;
		hi = SAT_W'(32'sh7FFF_FFFF);
		lo = SAT_W'(32'sh8000_0000);
		if (v > hi) begin
			return hi[WORD_W-1:0];
		end else if (v < lo) begin
			return lo[WORD_W-1:0];
		end
		return v[WORD_W-1:0];
	endfunction

endpackage

### rtl/core/efp_cfg.sv
module efp_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wen,
	input  logic [efp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [efp_pkg::WORD_W-1:0]      cfg_data,
	output efp_pkg::cfg_t                   cfg
);

	efp_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode   <= efp_pkg::MODE_MANDEL;
			cfg_q.left   <= efp_pkg::RST_LEFT;
			cfg_q.right  <= efp_pkg::RST_RIGHT;
			cfg_q.top    <= efp_pkg::RST_TOP;
			cfg_q.bottom <= efp_pkg::RST_BOTTOM;
			cfg_q.limit  <= efp_pkg::RST_LIMIT;
			cfg_q.step   <= efp_pkg::RST_STEP;
		end else if (cfg_wen) begin
			unique case (efp_pkg::cfg_reg_t'(cfg_index))
				efp_pkg::REG_MODE:   cfg_q.mode   <= efp_pkg::fractal_mode_t'(cfg_data[0]);
				efp_pkg::REG_LEFT:   cfg_q.left   <= $signed(cfg_data);
				efp_pkg::REG_RIGHT:  cfg_q.right  <= $signed(cfg_data);
				efp_pkg::REG_TOP:    cfg_q.top    <= $signed(cfg_data);
				efp_pkg::REG_BOTTOM: cfg_q.bottom <= $signed(cfg_data);
				efp_pkg::REG_LIMIT:  cfg_q.limit  <= cfg_data[efp_pkg::LIMIT_W-1:0];
				efp_pkg::REG_STEP:   cfg_q.step   <= cfg_data[efp_pkg::STEP_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### rtl/core/efp_cplx_sq.sv
module efp_cplx_sq (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [efp_pkg::WORD_W-1:0]   x,
	input  logic signed [efp_pkg::WORD_W-1:0]   y,
	output logic [efp_pkg::SQ_W-1:0]            sq_x,
	output logic [efp_pkg::SQ_W-1:0]            sq_y,
	output logic [efp_pkg::XY_W-1:0]            xy2,
	output logic                                neg
);

	logic [efp_pkg::WORD_W-1:0] mag_x;
	logic [efp_pkg::WORD_W-1:0] mag_y;
	logic [efp_pkg::PROD_W-1:0] p_xx;
	logic [efp_pkg::PROD_W-1:0] p_yy;
	logic [efp_pkg::PROD_W-1:0] p_xy;
	logic [efp_pkg::SQ_W-1:0]   sq_x_q;
	logic [efp_pkg::SQ_W-1:0]   sq_y_q;
	logic [efp_pkg::XY_W-1:0]   xy2_q;
	logic                       neg_q;

	// most negative value maps to 2^31, still fits unsigned
	assign mag_x = x[efp_pkg::WORD_W-1] ? efp_pkg::WORD_W'(-x) : efp_pkg::WORD_W'(x);
	assign mag_y = y[efp_pkg::WORD_W-1] ? efp_pkg::WORD_W'(-y) : efp_pkg::WORD_W'(y);

	assign p_xx = efp_pkg::PROD_W'(mag_x) * efp_pkg::PROD_W'(mag_x);
	assign p_yy = efp_pkg::PROD_W'(mag_y) * efp_pkg::PROD_W'(mag_y);
	assign p_xy = efp_pkg::PROD_W'(mag_x) * efp_pkg::PROD_W'(mag_y);

	always_ff @(posedge clk) begin
		if (en) begin
			sq_x_q <= p_xx[efp_pkg::PROD_W-1:efp_pkg::FRACTION_BITS];
			sq_y_q <= p_yy[efp_pkg::PROD_W-1:efp_pkg::FRACTION_BITS];
			// (2*p) >> F
			xy2_q  <= p_xy[efp_pkg::PROD_W-1:efp_pkg::FRACTION_BITS-1];
			neg_q  <= x[efp_pkg::WORD_W-1] ^ y[efp_pkg::WORD_W-1];
		end
	end

	assign sq_x = sq_x_q;
	assign sq_y = sq_y_q;
	assign xy2  = xy2_q;
	assign neg  = neg_q;

endmodule

### rtl/core/efp_seq.sv
module efp_seq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  efp_pkg::seq_stat_t   stat,
	output efp_pkg::seq_ctl_t    ctl
);

	efp_pkg::fsm_state_t state_q;
	efp_pkg::fsm_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= efp_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			efp_pkg::ST_IDLE: begin
				if (in_valid) state_nxt = efp_pkg::ST_MAP;
			end
			efp_pkg::ST_MAP:  state_nxt = efp_pkg::ST_LOAD;
			efp_pkg::ST_LOAD: state_nxt = efp_pkg::ST_MUL;
			efp_pkg::ST_MUL:  state_nxt = efp_pkg::ST_STEP;
			efp_pkg::ST_STEP: begin
				if (stat.escaped || stat.at_limit) begin
					state_nxt = efp_pkg::ST_PAINT;
				end else begin
					state_nxt = efp_pkg::ST_MUL;
				end
			end
			efp_pkg::ST_PAINT: state_nxt = efp_pkg::ST_EMIT;
			efp_pkg::ST_EMIT: begin
				if (!stat.out_hold) state_nxt = efp_pkg::ST_IDLE;
			end
			default: state_nxt = efp_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		unique case (state_q)
			efp_pkg::ST_IDLE:  ctl.take = in_valid;
			efp_pkg::ST_MAP:   ctl.map = 1'b1;
			efp_pkg::ST_LOAD:  ctl.load = 1'b1;
			efp_pkg::ST_MUL:   ctl.mul = 1'b1;
			efp_pkg::ST_STEP:  ctl.step = 1'b1;
			efp_pkg::ST_PAINT: ctl.paint = 1'b1;
			efp_pkg::ST_EMIT:  ctl.emit = !stat.out_hold;
			default: ;
		endcase
		ctl.busy = (state_q != efp_pkg::ST_IDLE);
	end

endmodule

### rtl/core/escape_time_fractal_pixel.sv
// channel | signals                        | beat taken when
// --------+--------------------------------+-----------------------
// input   | in_valid, in_stall, in_data    | in_valid && !in_stall
// output  | out_valid, out_stall, out_data | out_valid && !out_stall
// config  | cfg_wen, cfg_index, cfg_data   | cfg_wen
//
// One pixel at a time, in the order map, load, iterate, paint, emit. The
// complex-square unit sets the pace: each iteration is a multiply state
// followed by an add/saturate/escape-compare state.
// Reset clears state and restores register defaults. A stalled result holds
// in the output register; the next pixel is taken while it waits.
module escape_time_fractal_pixel (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  efp_pkg::in_beat_t               in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output efp_pkg::out_beat_t              out_data,
	input  logic                            cfg_wen,
	input  logic [efp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [efp_pkg::WORD_W-1:0]      cfg_data
);

	efp_pkg::cfg_t      cfg;
	efp_pkg::seq_ctl_t  ctl;
	efp_pkg::seq_stat_t stat;

	efp_pkg::in_beat_t  in_q;
	efp_pkg::out_beat_t out_data_q;
	logic               out_valid_q;

	logic signed [efp_pkg::MAP_W-1:0]  map_re_q;
	logic signed [efp_pkg::MAP_W-1:0]  map_im_q;
	logic signed [efp_pkg::WORD_W-1:0] cre_q;
	logic signed [efp_pkg::WORD_W-1:0] cim_q;
	logic signed [efp_pkg::WORD_W-1:0] x_q;
	logic signed [efp_pkg::WORD_W-1:0] y_q;
	logic [efp_pkg::LIMIT_W-1:0]       count_q;
	logic                              pend_q;
	logic [efp_pkg::BYTE_W-1:0]        base_q;

	logic signed [efp_pkg::DIFF_W-1:0] diff_re;
	logic signed [efp_pkg::DIFF_W-1:0] diff_im;
	logic signed [efp_pkg::MAP_W-1:0]  rnd_re;
	logic signed [efp_pkg::MAP_W-1:0]  rnd_im;
	logic signed [efp_pkg::MAP_W-1:0]  off_re;
	logic signed [efp_pkg::MAP_W-1:0]  off_im;
	logic signed [efp_pkg::WORD_W-1:0] cre;
	logic signed [efp_pkg::WORD_W-1:0] cim;

	logic [efp_pkg::SQ_W-1:0]          sq_x;
	logic [efp_pkg::SQ_W-1:0]          sq_y;
	logic [efp_pkg::XY_W-1:0]          xy2;
	logic                              neg;
	logic signed [efp_pkg::SAT_W-1:0]  ext_sx;
	logic signed [efp_pkg::SAT_W-1:0]  ext_sy;
	logic signed [efp_pkg::SAT_W-1:0]  ext_xy;
	logic signed [efp_pkg::SAT_W-1:0]  xy_term;
	logic signed [efp_pkg::WORD_W-1:0] x_new;
	logic signed [efp_pkg::WORD_W-1:0] y_new;
	logic [efp_pkg::PROD_W:0]          esc_sum;
	logic [efp_pkg::LIMIT_W:0]         cnt_next;

	efp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	efp_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.stat     (stat),
		.ctl      (ctl)
	);

	efp_cplx_sq u_sq (
		.clk  (clk),
		.en   (ctl.mul),
		.x    (x_q),
		.y    (y_q),
		.sq_x (sq_x),
		.sq_y (sq_y),
		.xy2  (xy2),
		.neg  (neg)
	);

	// pixel to window mapping, division by image size truncates toward zero
	assign diff_re = efp_pkg::DIFF_W'(cfg.right) - efp_pkg::DIFF_W'(cfg.left);
	assign diff_im = efp_pkg::DIFF_W'(cfg.bottom) - efp_pkg::DIFF_W'(cfg.top);

	assign rnd_re = map_re_q[efp_pkg::MAP_W-1] ? efp_pkg::MAP_W'(efp_pkg::IMAGE_WIDTH - 1)
	                                           : efp_pkg::MAP_W'(0);
	assign rnd_im = map_im_q[efp_pkg::MAP_W-1] ? efp_pkg::MAP_W'(efp_pkg::IMAGE_HEIGHT - 1)
	                                           : efp_pkg::MAP_W'(0);
	assign off_re = (map_re_q + rnd_re) >>> efp_pkg::IMAGE_WIDTH_LOG2;
	assign off_im = (map_im_q + rnd_im) >>> efp_pkg::IMAGE_HEIGHT_LOG2;

	assign cre = efp_pkg::sat_word(efp_pkg::SAT_W'(cfg.left) + efp_pkg::SAT_W'(off_re));
	assign cim = efp_pkg::sat_word(efp_pkg::SAT_W'(cfg.top) + efp_pkg::SAT_W'(off_im));

	// iteration update from the registered products
	assign ext_sx  = $signed(efp_pkg::SAT_W'(sq_x));
	assign ext_sy  = $signed(efp_pkg::SAT_W'(sq_y));
	assign ext_xy  = $signed(efp_pkg::SAT_W'(xy2));
	assign xy_term = (cfg.mode == efp_pkg::MODE_MANDEL && neg) ? -ext_xy : ext_xy;
	assign x_new   = efp_pkg::sat_word(ext_sx - ext_sy + efp_pkg::SAT_W'(cre_q));
	assign y_new   = efp_pkg::sat_word(xy_term + efp_pkg::SAT_W'(cim_q));

	// squares of the last update double as its escape test
	assign esc_sum  = (efp_pkg::PROD_W + 1)'(sq_x) + (efp_pkg::PROD_W + 1)'(sq_y);
	assign cnt_next = pend_q ? ((efp_pkg::LIMIT_W + 1)'(count_q) + 1'b1)
	                         : (efp_pkg::LIMIT_W + 1)'(count_q);

	assign stat.escaped  = pend_q && (esc_sum > efp_pkg::ESC_BOUND);
	assign stat.at_limit = cnt_next >= (efp_pkg::LIMIT_W + 1)'(cfg.limit);
	assign stat.out_hold = out_valid_q && out_stall;

	always_ff @(posedge clk) begin
		if (ctl.take) begin
			in_q <= in_data;
		end
		if (ctl.map) begin
			map_re_q <= efp_pkg::MAP_W'($signed({1'b0, in_q.pixel_col}))
			            * efp_pkg::MAP_W'(diff_re);
			map_im_q <= efp_pkg::MAP_W'($signed({1'b0, in_q.pixel_row}))
			            * efp_pkg::MAP_W'(diff_im);
		end
		if (ctl.load) begin
			cre_q   <= cre;
			cim_q   <= cim;
			x_q     <= cre;
			y_q     <= cim;
			count_q <= '0;
		end else if (ctl.step) begin
			x_q <= x_new;
			y_q <= y_new;
			if (!stat.escaped) count_q <= cnt_next[efp_pkg::LIMIT_W-1:0];
		end
		if (ctl.paint) begin
			base_q <= efp_pkg::BYTE_W'(count_q * cfg.step);
		end
		if (ctl.emit) begin
			out_data_q.pixel_word_index <=
				efp_pkg::INDEX_W'(efp_pkg::INDEX_W'(in_q.pixel_row)
				* efp_pkg::INDEX_W'(efp_pkg::ROW_PITCH))
				+ efp_pkg::INDEX_W'(in_q.pixel_col);
			out_data_q.escape_count <= count_q;
			out_data_q.red_byte     <= efp_pkg::BYTE_W'((base_q
				+ efp_pkg::BYTE_W'(efp_pkg::RED_OFFSET)) * in_q.shade);
			out_data_q.green_byte   <= efp_pkg::BYTE_W'((base_q
				+ efp_pkg::BYTE_W'(efp_pkg::GREEN_OFFSET)) * in_q.shade);
			out_data_q.blue_byte    <= efp_pkg::BYTE_W'((base_q
				+ efp_pkg::BYTE_W'(efp_pkg::BLUE_OFFSET)) * in_q.shade);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.load) begin
				pend_q <= 1'b0;
			end else if (ctl.step) begin
				pend_q <= 1'b1;
			end
			if (ctl.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = ctl.busy;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

### rtl/core/efp_checker.sv
module efp_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_stall,
	input logic                            out_valid,
	input logic                            out_stall,
	input efp_pkg::out_beat_t              out_data,
	input logic                            cfg_wen,
	input logic [efp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input logic [efp_pkg::WORD_W-1:0]      cfg_data
);

	logic [efp_pkg::LIMIT_W-1:0] limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= efp_pkg::RST_LIMIT;
		end else if (cfg_wen && cfg_index == efp_pkg::REG_LIMIT) begin
			limit_q <= cfg_data[efp_pkg::LIMIT_W-1:0];
		end
	end

	// held result beat must not move
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result beat changed while stalled");

	// one pixel in flight: busy right after taking a beat
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while pixel still in work");

	// a fresh result never counts past the limit
	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> out_data.escape_count <= limit_q)
		else $error("escape count above iteration limit");

	// no input beat offered: pixel engine stays idle
	a_no_result_from_nothing: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall && !in_valid |=> !in_stall)
		else $error("engine started without an input beat");

endmodule

bind escape_time_fractal_pixel efp_checker u_efp_checker (.*);

### dv/escape_time_fractal_pixel_tb.sv
module escape_time_fractal_pixel_tb;
	import efp_pkg::*;

	localparam longint Q_ONE = longint'(1) << FRACTION_BITS;
	localparam longint unsigned ESCAPE_LIMIT = 64'd4 << FRACTION_BITS;
	localparam longint WORD_MAX = 64'sd2147483647;
	localparam longint WORD_MIN = -64'sd2147483648;
	localparam logic [CFG_IDX_W-1:0] UNUSED_REG = 3'd7;
	localparam int IDLE_PCT = 29;
	localparam int CYCLE_LIMIT = 1_500_000;
	// deep-zoom spot on the set boundary, used with the largest limit
	localparam longint DEEP_RE = -64'sd199608605;
	localparam longint DEEP_IM = 64'sd35379793;
	localparam longint DEEP_HALF = 64'sd262144;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_beat_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_beat_t out_data;
	logic cfg_wen = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [WORD_W-1:0] cfg_data = '0;

	cfg_t active_cfg;
	out_beat_t pending_pixels[$];
	bit gaps_on = 1'b1;
	int unsigned pixels_sent = 0;
	int unsigned pixels_checked = 0;
	int unsigned mismatches = 0;
	int unsigned settings_used = 0;
	int unsigned min_count = 1023;
	int unsigned max_count = 0;
	int unsigned cycle_count = 0;

	escape_time_fractal_pixel dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, pending_pixels.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	// ---------------- pixel predictor ----------------

	function automatic longint clamp_word(longint v);
		if (v > WORD_MAX) return WORD_MAX;
		if (v < WORD_MIN) return WORD_MIN;
		return v;
	endfunction

	function automatic longint unsigned magnitude(longint v);
		return (v < 0) ? longint'(-v) : v;
	endfunction

	function automatic longint unsigned square_q(longint v);
		longint unsigned m;
		m = magnitude(v);
		return (m * m) >> FRACTION_BITS;
	endfunction

	// linear map of a pixel into [lo_edge, hi_edge), division truncates toward zero
	function automatic longint map_coord(longint lo_edge, longint hi_edge, longint pix,
			longint span);
		longint offset;
		offset = (pix * (hi_edge - lo_edge)) / span;
		return clamp_word(lo_edge + offset);
	endfunction

	function automatic out_beat_t render_pixel(in_beat_t px);
		out_beat_t res;
		longint c_re, c_im, x, y, xy_term, re_next, im_next;
		int unsigned count, shade_base;
		bit escaped;
		c_re = map_coord($signed(active_cfg.left), $signed(active_cfg.right),
			px.pixel_col, IMAGE_WIDTH);
		c_im = map_coord($signed(active_cfg.top), $signed(active_cfg.bottom),
			px.pixel_row, IMAGE_HEIGHT);
		x = c_re;
		y = c_im;
		count = 0;
		escaped = 1'b0;
		while (!escaped && count < active_cfg.limit) begin
			xy_term = longint'((64'd2 * magnitude(x) * magnitude(y)) >> FRACTION_BITS);
			if (((x < 0) != (y < 0)) && active_cfg.mode == MODE_MANDEL)
				xy_term = -xy_term;
			re_next = clamp_word(longint'(square_q(x)) - longint'(square_q(y)) + c_re);
			im_next = clamp_word(xy_term + c_im);
			x = re_next;
			y = im_next;
			// escaping step does not count
			if (square_q(x) + square_q(y) > ESCAPE_LIMIT)
				escaped = 1'b1;
			else
				count++;
		end
		shade_base = count * active_cfg.step;
		res.pixel_word_index = INDEX_W'(px.pixel_row * ROW_PITCH + px.pixel_col);
		res.escape_count = LIMIT_W'(count);
		res.red_byte = BYTE_W'((shade_base + RED_OFFSET) * px.shade);
		res.green_byte = BYTE_W'((shade_base + GREEN_OFFSET) * px.shade);
		res.blue_byte = BYTE_W'((shade_base + BLUE_OFFSET) * px.shade);
		return res;
	endfunction

	// ---------------- result checking ----------------

	function automatic void check_field(string what, int unsigned want, int unsigned got);
		if (want != got) begin
			mismatches++;
			$display("%0t %s: expected %0d, got %0d", $time, what, want, got);
		end
	endfunction

	always @(posedge clk) begin : check_results
		out_beat_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_pixels.size() == 0) begin
				mismatches++;
				$display("%0t unexpected result beat: expected none, got %h", $time, out_data);
			end else begin
				want = pending_pixels.pop_front();
				check_field("pixel_word_index", 32'(want.pixel_word_index),
					32'(out_data.pixel_word_index));
				check_field("escape_count", 32'(want.escape_count),
					32'(out_data.escape_count));
				check_field("red_byte", 32'(want.red_byte), 32'(out_data.red_byte));
				check_field("green_byte", 32'(want.green_byte), 32'(out_data.green_byte));
				check_field("blue_byte", 32'(want.blue_byte), 32'(out_data.blue_byte));
				pixels_checked++;
				if (32'(want.escape_count) < min_count) min_count = 32'(want.escape_count);
				if (32'(want.escape_count) > max_count) max_count = 32'(want.escape_count);
			end
		end
	end

	always @(negedge clk)
		out_stall <= gaps_on && ($urandom_range(99) < IDLE_PCT);

	// ---------------- drivers ----------------

	task automatic send_pixel(input logic [PIX_W-1:0] col, input logic [PIX_W-1:0] row,
			input logic [SHADE_W-1:0] shade);
		in_beat_t beat;
		beat.pixel_col = col;
		beat.pixel_row = row;
		beat.shade = shade;
		while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= beat;
		do @(posedge clk); while (in_stall);
		pending_pixels.push_back(render_pixel(beat));
		pixels_sent++;
	endtask

	task automatic send_random_pixel();
		send_pixel(PIX_W'($urandom_range(1023)), PIX_W'($urandom_range(1023)),
			SHADE_W'($urandom_range(255)));
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] value);
		@(negedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			REG_MODE:   active_cfg.mode = fractal_mode_t'(value[0]);
			REG_LEFT:   active_cfg.left = value;
			REG_RIGHT:  active_cfg.right = value;
			REG_TOP:    active_cfg.top = value;
			REG_BOTTOM: active_cfg.bottom = value;
			REG_LIMIT:  active_cfg.limit = value[LIMIT_W-1:0];
			REG_STEP:   active_cfg.step = value[STEP_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_wen <= 1'b0;
	endtask

	task automatic set_config(input fractal_mode_t mode, input logic [WORD_W-1:0] left,
			input logic [WORD_W-1:0] right, input logic [WORD_W-1:0] top,
			input logic [WORD_W-1:0] bottom, input logic [LIMIT_W-1:0] limit,
			input logic [STEP_W-1:0] step);
		wait_drained();
		write_reg(REG_MODE, WORD_W'(mode));
		write_reg(REG_LEFT, left);
		write_reg(REG_RIGHT, right);
		write_reg(REG_TOP, top);
		write_reg(REG_BOTTOM, bottom);
		write_reg(REG_LIMIT, WORD_W'(limit));
		write_reg(REG_STEP, WORD_W'(step));
		settings_used++;
	endtask

	// ---------------- tests ----------------

	task automatic test_reset_defaults();
		send_pixel(10'd0, 10'd0, 8'd0);
		send_pixel(10'd1023, 10'd1023, 8'd255);
		send_pixel(10'd512, 10'd512, 8'd1);    // c = 0, runs to the limit
		send_pixel(10'd1023, 10'd0, 8'hAA);
		send_pixel(10'd0, 10'd1023, 8'h55);
	endtask

	task automatic test_modes_and_limits();
		set_config(MODE_SHIP, -32'sd536870912, 32'sd268435456, -32'sd536870912,
			32'sd268435456, 10'd100, 8'd7);
		send_pixel(10'd300, 10'd700, 8'd255);
		send_pixel(10'd900, 10'd100, 8'd3);
		// zero limit: no iteration at all
		set_config(MODE_MANDEL, -32'sd805306368, 32'sd268435456, -32'sd402653184,
			32'sd402653184, 10'd0, 8'd255);
		send_pixel(10'd512, 10'd512, 8'd255);
		send_pixel(10'd1, 10'd2, 8'd128);
		set_config(MODE_SHIP, -32'sd805306368, 32'sd268435456, -32'sd402653184,
			32'sd402653184, 10'd1, 8'd0);
		send_pixel(10'd700, 10'd512, 8'd77);
	endtask

	task automatic test_window_extremes();
		set_config(MODE_MANDEL, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			10'd100, 8'd255);
		send_pixel(10'd0, 10'd0, 8'd255);
		send_pixel(10'd1023, 10'd1023, 8'd255);
		send_pixel(10'd511, 10'd700, 8'h81);
		// inverted window
		set_config(MODE_SHIP, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
			10'd50, 8'd19);
		send_pixel(10'd0, 10'd1023, 8'd200);
		send_pixel(10'd600, 10'd400, 8'd13);
		// collapsed window far outside: iterate saturates on first step
		set_config(MODE_MANDEL, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			10'd1023, 8'd1);
		send_pixel(10'd345, 10'd678, 8'd9);
		// empty window at the origin: every pixel runs the full limit
		set_config(MODE_MANDEL, 32'h0, 32'h0, 32'h0, 32'h0, 10'd1023, 8'd0);
		send_pixel(10'd1023, 10'd0, 8'd255);
	endtask

	task automatic test_unused_register();
		set_config(MODE_MANDEL, -32'sd536870912, 32'sd536870912, -32'sd536870912,
			32'sd536870912, 10'd60, 8'd5);
		write_reg(UNUSED_REG, 32'hFFFF_FFFF);
		send_pixel(10'd400, 10'd600, 8'd201);
		send_pixel(10'd256, 10'd768, 8'd254);
	endtask

	task automatic test_random_settings();
		fractal_mode_t mode;
		longint half, c_re, c_im, swap;
		logic [WORD_W-1:0] left, right, top, bottom;
		logic [LIMIT_W-1:0] limit;
		logic [STEP_W-1:0] step;
		int unsigned pick;
		for (int phase = 0; phase < 16; phase++) begin
			mode = fractal_mode_t'($urandom_range(1));
			if ($urandom_range(4) == 0) begin
				left = $urandom();
				right = $urandom();
				top = $urandom();
				bottom = $urandom();
			end else begin
				// window somewhere over the interesting part of the plane
				half = longint'($urandom_range(32'(2 * Q_ONE), 32'(Q_ONE / 256)));
				c_re = -2 * Q_ONE + longint'($urandom_range(32'(5 * Q_ONE / 2)));
				c_im = -(6 * Q_ONE / 5) + longint'($urandom_range(32'(12 * Q_ONE / 5)));
				left = WORD_W'(c_re - half);
				right = WORD_W'(c_re + half);
				top = WORD_W'(c_im - half);
				bottom = WORD_W'(c_im + half);
				if ($urandom_range(3) == 0) begin
					swap = longint'(left);
					left = right;
					right = WORD_W'(swap);
				end
			end
			pick = $urandom_range(9);
			if (pick == 0) limit = LIMIT_W'($urandom_range(3));
			else if (pick == 8) limit = LIMIT_W'($urandom_range(255));
			else if (pick == 9) limit = RST_LIMIT;
			else limit = LIMIT_W'($urandom_range(120));
			pick = $urandom_range(7);
			if (pick == 0) step = 8'd0;
			else if (pick == 1) step = 8'd255;
			else step = STEP_W'($urandom_range(255));
			set_config(mode, left, right, top, bottom, limit, step);
			for (int i = 0; i < 25; i++)
				send_random_pixel();
		end
	endtask

	task automatic test_back_to_back();
		set_config(MODE_MANDEL, -32'sd603979776, 32'sd134217728, -32'sd335544320,
			32'sd335544320, 10'd40, 8'd3);
		gaps_on = 1'b0;
		for (int i = 0; i < 30; i++)
			send_random_pixel();
		// hold off until every outstanding beat is back, then resume
		wait_drained();
		for (int i = 0; i < 30; i++)
			send_random_pixel();
		gaps_on = 1'b1;
	endtask

	task automatic test_deep_limit();
		for (int m = 0; m < 2; m++) begin
			set_config(fractal_mode_t'(m), WORD_W'(DEEP_RE - DEEP_HALF),
				WORD_W'(DEEP_RE + DEEP_HALF), WORD_W'(DEEP_IM - DEEP_HALF),
				WORD_W'(DEEP_IM + DEEP_HALF), 10'd1023, STEP_W'($urandom_range(255)));
			for (int i = 0; i < 4; i++)
				send_random_pixel();
		end
	endtask

	initial begin
		active_cfg = '{MODE_MANDEL, RST_LEFT, RST_RIGHT, RST_TOP, RST_BOTTOM,
			RST_LIMIT, RST_STEP};
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_modes_and_limits();
		test_window_extremes();
		test_unused_register();
		test_random_settings();
		test_back_to_back();
		test_deep_limit();

		wait_drained();
		repeat (40) @(posedge clk);
		$display("checked %0d of %0d pixels over %0d register settings, both fractal modes",
			pixels_checked, pixels_sent, settings_used);
		$display("escape counts seen from %0d to %0d, %0d mismatches",
			min_count, max_count, mismatches);
		if (mismatches == 0 && pending_pixels.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

### files.f
rtl/core/efp_pkg.sv
rtl/core/efp_cfg.sv
rtl/core/efp_cplx_sq.sv
rtl/core/efp_seq.sv
rtl/core/escape_time_fractal_pixel.sv
rtl/core/efp_checker.sv
dv/escape_time_fractal_pixel_tb.sv
